// ----- hdl/phv_pkg.sv -----
// Shared types, widths and helpers for the point height variance block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package phv_pkg;

    // Field widths
    localparam int COORD_W = 16;
    localparam int VAR_W   = 32;
    localparam int FLD_W   = 16;
    localparam int COV_W   = 10;
    localparam int CFG_W   = 64;
    localparam int VEC_W   = 3 * FLD_W;
    localparam int COVP_W  = 6 * COV_W;

    // Stream word widths, padded to whole bytes
    localparam int S_TDATA_W = ((3 * COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAR_W + 7) / 8) * 8;

    // Distance path
    localparam int SQ_W = 2 * COORD_W;
    localparam int D_W  = COORD_W;

    // Rotated point v = (R*p) >> 14
    localparam int PRD_W = FLD_W + COORD_W;
    localparam int P_W   = PRD_W + 2;
    localparam int V_W   = P_W - 14;

    // Queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROT_ROW0,
        REG_ROT_ROW1,
        REG_ROT_ROW2,
        REG_MAP_PROJ,
        REG_OFFSET_JAC,
        REG_SENSOR_JAC,
        REG_ROT_COV,
        REG_NOISE_MODEL
    } phv_reg_t;

    typedef struct packed {
        logic [VEC_W-1:0]  rot_row0;
        logic [VEC_W-1:0]  rot_row1;
        logic [VEC_W-1:0]  rot_row2;
        logic [VEC_W-1:0]  map_proj;
        logic [VEC_W-1:0]  offset_jac;
        logic [VEC_W-1:0]  sensor_jac;
        logic [COVP_W-1:0] rot_cov;
        logic [CFG_W-1:0]  noise;
    } phv_cfg_t;

    // One classified point handed from front to back
    typedef struct packed {
        logic [SQ_W-1:0]       sq;
        logic signed [V_W-1:0] v0;
        logic signed [V_W-1:0] v1;
        logic signed [V_W-1:0] v2;
    } phv_item_t;

    // Signed 16-bit element of a packed three-element vector
    function automatic logic signed [FLD_W-1:0] vec_elem(input logic [VEC_W-1:0] vec,
                                                         input int idx);
        return $signed(vec[idx*FLD_W +: FLD_W]);
    endfunction

    // Signed 10-bit element of the packed covariance
    function automatic logic signed [COV_W-1:0] cov_elem(input logic [COVP_W-1:0] cov,
                                                         input int idx);
        return $signed(cov[idx*COV_W +: COV_W]);
    endfunction

endpackage

`default_nettype wire

// ----- hdl/point_height_variance.sv -----
// Throughput: one point per cycle while the output is not stalled; the square root is
// one bit per stage, so every unit is a pipeline stage and none is shared.
// A four-entry queue lets input and output stall independently.
// Reset (aresetn low, synchronous) zeroes all registers of the config port and
// empties the input stage, the queue and the pipeline.
`default_nettype none

module point_height_variance (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: point_x, point_y, point_z
    input  wire logic [phv_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: height_variance
    output logic [phv_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: saturated
    output logic                               m_tuser,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [phv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [phv_pkg::CFG_W-1:0]     cfg_data
);
    import phv_pkg::*;

    phv_cfg_t  cfg_reg, cfg_next;
    logic      front_valid, front_ready;
    phv_item_t front_item;
    logic      back_valid, back_ready;
    phv_item_t back_item;

    assign cfg_ready = 1'b1;

    // Register writes; unknown indexes fall through
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (phv_reg_t'(cfg_index))
                REG_ROT_ROW0:    cfg_next.rot_row0   = cfg_data[VEC_W-1:0];
                REG_ROT_ROW1:    cfg_next.rot_row1   = cfg_data[VEC_W-1:0];
                REG_ROT_ROW2:    cfg_next.rot_row2   = cfg_data[VEC_W-1:0];
                REG_MAP_PROJ:    cfg_next.map_proj   = cfg_data[VEC_W-1:0];
                REG_OFFSET_JAC:  cfg_next.offset_jac = cfg_data[VEC_W-1:0];
                REG_SENSOR_JAC:  cfg_next.sensor_jac = cfg_data[VEC_W-1:0];
                REG_ROT_COV:     cfg_next.rot_cov    = cfg_data[COVP_W-1:0];
                REG_NOISE_MODEL: cfg_next.noise      = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    phv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg        (cfg_reg),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    phv_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    phv_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .cfg        (cfg_reg),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

// ----- hdl/phv_front.sv -----
// Front part: accepts points, forms the sum of squares and the rotated point.
// Depends on phv_pkg.
`default_nettype none

module phv_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // s_tdata: point_x, point_y, point_z
    input  wire logic [phv_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire phv_pkg::phv_cfg_t             cfg,
    output logic                               item_valid,
    input  wire logic                          item_ready,
    output phv_pkg::phv_item_t                 item
);
    import phv_pkg::*;

    logic                      pt_vld_reg, pt_vld_next;
    logic signed [COORD_W-1:0] pt_reg [3];
    logic signed [PRD_W-1:0]   prod [3][3];
    logic signed [SQ_W-1:0]    sqr [3];
    logic signed [P_W-1:0]     rp [3];

    // Take a new point whenever the held one moves on
    assign s_tready   = !pt_vld_reg || item_ready;
    assign item_valid = pt_vld_reg;

    always_comb begin
        pt_vld_next = pt_vld_reg;
        if (s_tready) begin
            pt_vld_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pt_vld_reg <= 1'b0;
        end else begin
            pt_vld_reg <= pt_vld_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            for (int i = 0; i < 3; i++) begin
                pt_reg[i] <= $signed(s_tdata[i*COORD_W +: COORD_W]);
            end
        end
    end

    // Squares and rotation products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            sqr[i] = pt_reg[i] * pt_reg[i];
        end
        prod[0][0] = vec_elem(cfg.rot_row0, 0) * pt_reg[0];
        prod[0][1] = vec_elem(cfg.rot_row0, 1) * pt_reg[1];
        prod[0][2] = vec_elem(cfg.rot_row0, 2) * pt_reg[2];
        prod[1][0] = vec_elem(cfg.rot_row1, 0) * pt_reg[0];
        prod[1][1] = vec_elem(cfg.rot_row1, 1) * pt_reg[1];
        prod[1][2] = vec_elem(cfg.rot_row1, 2) * pt_reg[2];
        prod[2][0] = vec_elem(cfg.rot_row2, 0) * pt_reg[0];
        prod[2][1] = vec_elem(cfg.rot_row2, 1) * pt_reg[1];
        prod[2][2] = vec_elem(cfg.rot_row2, 2) * pt_reg[2];
        for (int i = 0; i < 3; i++) begin
            rp[i] = P_W'(prod[i][0]) + P_W'(prod[i][1]) + P_W'(prod[i][2]);
        end
    end

    // Floor shifts are the upper bits of the sums
    assign item.sq = SQ_W'($unsigned(sqr[0])) + SQ_W'($unsigned(sqr[1]))
                   + SQ_W'($unsigned(sqr[2]));
    assign item.v0 = $signed(rp[0][P_W-1:14]);
    assign item.v1 = $signed(rp[1][P_W-1:14]);
    assign item.v2 = $signed(rp[2][P_W-1:14]);

endmodule

`default_nettype wire

// ----- hdl/phv_fifo.sv -----
// Short queue of classified points between the front and back parts.
// Depends on phv_pkg.
`default_nettype none

module phv_fifo (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire phv_pkg::phv_item_t push_item,
    output logic                    pop_valid,
    input  wire logic               pop_ready,
    output phv_pkg::phv_item_t      pop_item
);
    import phv_pkg::*;

    phv_item_t               mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;
    logic                    push, pop;

    assign push_ready = count_reg != FIFO_CNT_W'(FIFO_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entry
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/phv_back.sv -----
// Back part: square root, noise model, rotation quadratic form, sum and clamp.
// Depends on phv_pkg; fed from phv_fifo.
`default_nettype none

module phv_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire phv_pkg::phv_item_t            item,
    input  wire phv_pkg::phv_cfg_t             cfg,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // m_tdata: height_variance
    output logic [phv_pkg::M_TDATA_W-1:0]      m_tdata,
    // m_tuser: saturated
    output logic                               m_tuser
);
    import phv_pkg::*;

    // Stage positions: 0 entry, 1..D_W root bits, then eight noise stages
    localparam int LAST    = D_W + 8;
    localparam int ADIFF_W = (D_W + 2 > 16) ? D_W + 2 : 16;
    localparam int SLP_W   = 16 + D_W;
    localparam int SL_W    = SLP_W - 10;
    localparam int VARL_W  = 2 * SL_W;
    localparam int NBD_W   = 16 + ADIFF_W;
    localparam int T2_W    = NBD_W + ADIFF_W;
    localparam int SN_W    = T2_W - 24 + 1;
    localparam int VARN_W  = 2 * SN_W;
    localparam int J2_W    = 2 * FLD_W;
    localparam int ZH_W    = J2_W + VARN_W - 28;
    localparam int LH_W    = J2_W + VARL_W - 28;
    localparam int ZT_W    = ZH_W + 1;
    localparam int LT_W    = LH_W + 1;
    localparam int SENS_W  = ((ZT_W > LT_W) ? ZT_W : LT_W) + 1;
    localparam int MV_W    = FLD_W + V_W;
    localparam int DF_W    = MV_W + 1;
    localparam int R_W     = DF_W - 14 + 1;
    localparam int RR_W    = 2 * R_W;
    localparam int SRR_W   = RR_W + COV_W + 1;
    localparam int PS_W    = SRR_W + 1;
    localparam int QF_W    = SRR_W + 3;
    localparam int QS_W    = QF_W - 8 - 1;
    localparam int QD_N    = LAST - 6 + 1;
    localparam int TOT_W   = ((SENS_W > QS_W) ? SENS_W : QS_W) + 1;

    logic                    en;
    logic [LAST:0]           vld_reg;
    logic                    out_vld_reg;
    logic [VAR_W-1:0]        out_var_reg;
    logic                    out_sat_reg;

    // Square root
    logic [SQ_W-1:0]         rem_reg [0:D_W];
    logic [D_W-1:0]          root_reg [0:D_W];
    logic [SQ_W-1:0]         rem_next [1:D_W];
    logic [D_W-1:0]          root_next [1:D_W];
    logic [SQ_W:0]           trial [0:D_W-1];

    // Noise model
    logic [15:0]             na, nb, nc, nk;
    logic [ADIFF_W-1:0]      d4, ncx, adiff;
    logic [ADIFF_W-1:0]      n1_adiff_reg, n2_adiff_reg;
    logic [SLP_W-1:0]        n1_slp_reg;
    logic [NBD_W-1:0]        n2_nbd_reg;
    logic [SL_W-1:0]         n2_sl_reg;
    logic [T2_W-1:0]         n3_t2_reg;
    logic [VARL_W-1:0]       n3_varl_reg, n4_varl_reg, n5_varl_reg;
    logic [SN_W-1:0]         n4_sn_reg;
    logic [VARN_W-1:0]       n5_varn_reg;
    logic [J2_W-1:0]         j2xy_reg, j2z_reg;
    logic signed [FLD_W-1:0] jx, jy, jz;
    logic signed [J2_W-1:0]  jxx, jyy, jzz;
    logic [ZH_W-1:0]         n6_zh_reg;
    logic [LH_W-1:0]         n6_lh_reg;
    logic [J2_W-1:0]         n6_zl_reg, n6_ll_reg;
    logic [J2_W+27:0]        zl_full, ll_full;
    logic [ZT_W-1:0]         n7_zt_reg;
    logic [LT_W-1:0]         n7_lt_reg;
    logic [SENS_W-1:0]       n8_sens_reg;

    // Rotation path
    logic signed [V_W-1:0]   a_v_reg [3];
    logic signed [MV_W-1:0]  r1_mv_reg [6];
    logic signed [DF_W-1:0]  df [3];
    logic signed [R_W-1:0]   r2_r_reg [3];
    logic signed [RR_W-1:0]  r3_rr_reg [6];
    logic signed [SRR_W-1:0] r4_srr_reg [6];
    logic signed [PS_W-1:0]  r5_ps_reg [3];
    logic signed [QF_W-1:0]  qf;
    logic [QS_W-1:0]         q_pos;
    logic [QS_W-1:0]         qd_reg [QD_N];

    logic [TOT_W-1:0]        total;

    // Whole pipeline moves when the output slot is free or being taken
    assign en         = !out_vld_reg || m_tready;
    assign item_ready = en;
    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = M_TDATA_W'(out_var_reg);
    assign m_tuser    = out_sat_reg;

    // Valid tracking
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg     <= {vld_reg[LAST-1:0], item_valid};
            out_vld_reg <= vld_reg[LAST];
        end
    end

    // One root bit per stage
    always_comb begin
        int b;
        for (int k = 0; k < D_W; k++) begin
            b = D_W - 1 - k;
            trial[k] = ((SQ_W + 1)'(root_reg[k]) << (b + 1)) + ((SQ_W + 1)'(1) << (2 * b));
            if ({1'b0, rem_reg[k]} >= trial[k]) begin
                rem_next[k+1]  = rem_reg[k] - trial[k][SQ_W-1:0];
                root_next[k+1] = root_reg[k] | (D_W'(1) << b);
            end else begin
                rem_next[k+1]  = rem_reg[k];
                root_next[k+1] = root_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= item.sq;
            root_reg[0] <= '0;
            for (int k = 1; k <= D_W; k++) begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
            end
        end
    end

    // Noise factors and sensor Jacobian squares
    assign na  = cfg.noise[15:0];
    assign nb  = cfg.noise[31:16];
    assign nc  = cfg.noise[47:32];
    assign nk  = cfg.noise[63:48];
    assign jx  = vec_elem(cfg.sensor_jac, 0);
    assign jy  = vec_elem(cfg.sensor_jac, 1);
    assign jz  = vec_elem(cfg.sensor_jac, 2);
    assign jxx = jx * jx;
    assign jyy = jy * jy;
    assign jzz = jz * jz;

    always_ff @(posedge aclk) begin
        j2xy_reg <= $unsigned(jxx) + $unsigned(jyy);
        j2z_reg  <= $unsigned(jzz);
    end

    // Distance difference magnitude 4d - c
    assign d4    = ADIFF_W'(root_reg[D_W]) << 2;
    assign ncx   = ADIFF_W'(nc);
    assign adiff = (d4 >= ncx) ? d4 - ncx : ncx - d4;

    // Split products by 2^28 so each multiply stays narrow
    assign zl_full = j2z_reg * n5_varn_reg[27:0];
    assign ll_full = j2xy_reg * n5_varl_reg[27:0];

    // Noise and sensor variance stages
    always_ff @(posedge aclk) begin
        if (en) begin
            n1_adiff_reg <= adiff;
            n1_slp_reg   <= nk * root_reg[D_W];
            n2_nbd_reg   <= nb * n1_adiff_reg;
            n2_adiff_reg <= n1_adiff_reg;
            n2_sl_reg    <= n1_slp_reg[SLP_W-1:10];
            n3_t2_reg    <= n2_nbd_reg * n2_adiff_reg;
            n3_varl_reg  <= n2_sl_reg * n2_sl_reg;
            n4_sn_reg    <= SN_W'(na) + SN_W'(n3_t2_reg[T2_W-1:24]);
            n4_varl_reg  <= n3_varl_reg;
            n5_varn_reg  <= n4_sn_reg * n4_sn_reg;
            n5_varl_reg  <= n4_varl_reg;
            n6_zh_reg    <= j2z_reg * n5_varn_reg[VARN_W-1:28];
            n6_zl_reg    <= zl_full[J2_W+27:28];
            n6_lh_reg    <= j2xy_reg * n5_varl_reg[VARL_W-1:28];
            n6_ll_reg    <= ll_full[J2_W+27:28];
            n7_zt_reg    <= ZT_W'(n6_zh_reg) + ZT_W'(n6_zl_reg);
            n7_lt_reg    <= LT_W'(n6_lh_reg) + LT_W'(n6_ll_reg);
            n8_sens_reg  <= SENS_W'(n7_zt_reg) + SENS_W'(n7_lt_reg);
        end
    end

    // Cross product differences; the floor shift and offset follow in the r2 stage
    always_comb begin
        df[0] = DF_W'(r1_mv_reg[0]) - DF_W'(r1_mv_reg[1]);
        df[1] = DF_W'(r1_mv_reg[2]) - DF_W'(r1_mv_reg[3]);
        df[2] = DF_W'(r1_mv_reg[4]) - DF_W'(r1_mv_reg[5]);
    end

    // Quadratic form total, negative clamps to zero
    assign qf    = QF_W'(r5_ps_reg[0]) + QF_W'(r5_ps_reg[1]) + QF_W'(r5_ps_reg[2]);
    assign q_pos = qf[QF_W-1] ? '0 : qf[QF_W-2:8];

    // Rotation Jacobian and quadratic form stages
    always_ff @(posedge aclk) begin
        if (en) begin
            a_v_reg[0]    <= item.v0;
            a_v_reg[1]    <= item.v1;
            a_v_reg[2]    <= item.v2;
            r1_mv_reg[0]  <= vec_elem(cfg.map_proj, 1) * a_v_reg[2];
            r1_mv_reg[1]  <= vec_elem(cfg.map_proj, 2) * a_v_reg[1];
            r1_mv_reg[2]  <= vec_elem(cfg.map_proj, 2) * a_v_reg[0];
            r1_mv_reg[3]  <= vec_elem(cfg.map_proj, 0) * a_v_reg[2];
            r1_mv_reg[4]  <= vec_elem(cfg.map_proj, 0) * a_v_reg[1];
            r1_mv_reg[5]  <= vec_elem(cfg.map_proj, 1) * a_v_reg[0];
            for (int i = 0; i < 3; i++) begin
                r2_r_reg[i] <= R_W'($signed(df[i][DF_W-1:14]))
                             + R_W'(vec_elem(cfg.offset_jac, i));
            end
            r3_rr_reg[0]  <= r2_r_reg[0] * r2_r_reg[0];
            r3_rr_reg[1]  <= r2_r_reg[0] * r2_r_reg[1];
            r3_rr_reg[2]  <= r2_r_reg[0] * r2_r_reg[2];
            r3_rr_reg[3]  <= r2_r_reg[1] * r2_r_reg[1];
            r3_rr_reg[4]  <= r2_r_reg[1] * r2_r_reg[2];
            r3_rr_reg[5]  <= r2_r_reg[2] * r2_r_reg[2];
            // Diagonal once, off-diagonal twice
            r4_srr_reg[0] <= cov_elem(cfg.rot_cov, 0) * r3_rr_reg[0];
            r4_srr_reg[1] <= (cov_elem(cfg.rot_cov, 1) * r3_rr_reg[1]) <<< 1;
            r4_srr_reg[2] <= (cov_elem(cfg.rot_cov, 2) * r3_rr_reg[2]) <<< 1;
            r4_srr_reg[3] <= cov_elem(cfg.rot_cov, 3) * r3_rr_reg[3];
            r4_srr_reg[4] <= (cov_elem(cfg.rot_cov, 4) * r3_rr_reg[4]) <<< 1;
            r4_srr_reg[5] <= cov_elem(cfg.rot_cov, 5) * r3_rr_reg[5];
            r5_ps_reg[0]  <= PS_W'(r4_srr_reg[0]) + PS_W'(r4_srr_reg[1]);
            r5_ps_reg[1]  <= PS_W'(r4_srr_reg[2]) + PS_W'(r4_srr_reg[3]);
            r5_ps_reg[2]  <= PS_W'(r4_srr_reg[4]) + PS_W'(r4_srr_reg[5]);
            // Hold the rotation term until the sensor term catches up
            qd_reg[0]     <= q_pos;
            for (int i = 1; i < QD_N; i++) begin
                qd_reg[i] <= qd_reg[i-1];
            end
        end
    end

    // Final sum and clamp
    assign total = TOT_W'(n8_sens_reg) + TOT_W'(qd_reg[QD_N-1]);

    always_ff @(posedge aclk) begin
        if (en) begin
            if (|total[TOT_W-1:VAR_W]) begin
                out_var_reg <= '1;
                out_sat_reg <= 1'b1;
            end else begin
                out_var_reg <= total[VAR_W-1:0];
                out_sat_reg <= 1'b0;
            end
        end
    end

    // Clamped results carry the all-ones code
    a_sat_code: assert property (@(posedge aclk) disable iff (!aresetn)
        out_vld_reg && out_sat_reg |-> out_var_reg == {VAR_W{1'b1}})
        else $error("saturated result without full-scale value");

    // Root stage leaves a remainder no larger than twice the root
    a_root_floor: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[D_W] |-> {1'b0, rem_reg[D_W]} <= ((SQ_W + 1)'(root_reg[D_W]) << 1))
        else $error("square root stage not the floor root");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (vld_reg == '0) && !out_vld_reg)
        else $error("pipeline holds items after reset");

endmodule

`default_nettype wire
